FILE: src/tpa_pkg.sv
// types and constants shared by the triangle primitive assembly files
`timescale 1ns / 1ps

package tpa_pkg;

  // part kinds as carried on the input channel
  localparam logic [1:0] KIND_LIST  = 2'd0;
  localparam logic [1:0] KIND_STRIP = 2'd1;
  localparam logic [1:0] KIND_FAN   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // seen count saturates here
  localparam logic [1:0] SEEN_FULL  = 2'd2;
  // last position of a list triple
  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] seen_count;
    logic       strip_parity;
    logic [1:0] list_phase;
    logic [1:0] active_kind;
  } tpa_ctrl_t;

  localparam tpa_ctrl_t CTRL_RESET = '{
    seen_count:   2'd0,
    strip_parity: 1'b0,
    list_phase:   2'd0,
    active_kind:  KIND_NONE
  };

endpackage

FILE: src/tpa_if.sv
// valid/ready channel interfaces for index items and triangle items
`timescale 1ns / 1ps

interface tpa_in_if #(
  parameter int INDEX_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] vertex_index;
  logic [1:0]             part_kind;
  logic                   part_start;

  modport source (output valid, output vertex_index, output part_kind, output part_start,
                  input ready);
  modport sink   (input valid, input vertex_index, input part_kind, input part_start,
                  output ready);
endinterface

interface tpa_out_if #(
  parameter int INDEX_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] corner_one;
  logic [INDEX_WIDTH-1:0] corner_two;
  logic [INDEX_WIDTH-1:0] corner_three;

  modport source (output valid, output corner_one, output corner_two, output corner_three,
                  input ready);
  modport sink   (input valid, input corner_one, input corner_two, input corner_three,
                  output ready);
endinterface

FILE: src/tpa_assemble.sv
// assembly rule for one index: next part state and the triangle it closes
`timescale 1ns / 1ps

module tpa_assemble #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic [INDEX_WIDTH-1:0] cur_index,
  input  logic [1:0]             part_kind,
  input  logic                   part_start,
  input  tpa_pkg::tpa_ctrl_t     ctrl,
  input  logic [INDEX_WIDTH-1:0] anchor_index,
  input  logic [INDEX_WIDTH-1:0] newer_index,
  input  logic [INDEX_WIDTH-1:0] older_index,
  output tpa_pkg::tpa_ctrl_t     ctrl_nxt,
  output logic [INDEX_WIDTH-1:0] anchor_nxt,
  output logic                   emit,
  output logic [INDEX_WIDTH-1:0] corner_one,
  output logic [INDEX_WIDTH-1:0] corner_two,
  output logic [INDEX_WIDTH-1:0] corner_three
);
  import tpa_pkg::*;

  tpa_ctrl_t ctrl_eff;

  always_comb begin
    ctrl_eff = ctrl;
    if (part_start) begin
      ctrl_eff.active_kind  = part_kind;
      ctrl_eff.seen_count   = 2'd0;
      ctrl_eff.strip_parity = 1'b0;
      ctrl_eff.list_phase   = 2'd0;
    end

    anchor_nxt   = (ctrl_eff.seen_count == 2'd0) ? cur_index : anchor_index;
    ctrl_nxt     = ctrl_eff;
    emit         = 1'b0;
    corner_one   = older_index;
    corner_two   = newer_index;
    corner_three = cur_index;

    unique case (ctrl_eff.active_kind)
      KIND_LIST: begin
        if (ctrl_eff.list_phase >= PHASE_LAST) begin
          emit                = 1'b1;
          ctrl_nxt.list_phase = 2'd0;
        end else begin
          ctrl_nxt.list_phase = ctrl_eff.list_phase + 2'd1;
        end
      end
      KIND_STRIP: begin
        if (ctrl_eff.seen_count >= SEEN_FULL) begin
          emit = 1'b1;
          // odd triangles swap their last two corners to keep the winding
          if (ctrl_eff.strip_parity) begin
            corner_two   = cur_index;
            corner_three = newer_index;
          end
          ctrl_nxt.strip_parity = ~ctrl_eff.strip_parity;
        end
      end
      KIND_FAN: begin
        if (ctrl_eff.seen_count >= SEEN_FULL) begin
          emit       = 1'b1;
          corner_one = anchor_nxt;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (ctrl_eff.seen_count < SEEN_FULL) begin
      ctrl_nxt.seen_count = ctrl_eff.seen_count + 2'd1;
    end
  end

endmodule

FILE: src/triangle_primitive_assembly_unit.sv
// top level of the triangle primitive assembly unit
`timescale 1ns / 1ps
//
// assembles triangles from a stream of vertex indices grouped into parts
// in_chan: one vertex index per item; part_start marks the first item of a
//   part and part_kind on that item picks list, strip, fan or ignored
// out_chan: one triangle per item as three corner indices; an index item
//   closes at most one triangle, and items that close none produce nothing
// path: an index item that closes a triangle is held in the input register,
//   and the triangle is then written to the result register on out_chan
// throughput: one index item per cycle, except while a closing item waits on a held result;
//   the assembly rule is a single combinational block between the two registers
// reset (rst_n low, synchronous): both stages empty, part kind set to
//   ignored, history indices and counters cleared
// stall: a held result stays on out_chan; the input register keeps moving
//   while the item in it closes no triangle or the result register frees up,
//   so in_chan only backs up once both stages hold pending work
//
module triangle_primitive_assembly_unit #(
  parameter int INDEX_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  tpa_in_if.sink    in_chan,
  tpa_out_if.source out_chan
);
  import tpa_pkg::*;

  // input register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [INDEX_WIDTH-1:0] s1_index_r;
  logic [1:0]             s1_kind_r;
  logic                   s1_start_r;

  // part state
  tpa_ctrl_t              ctrl_r;
  tpa_ctrl_t              ctrl_nxt;
  logic [INDEX_WIDTH-1:0] anchor_r;
  logic [INDEX_WIDTH-1:0] anchor_nxt;
  logic [INDEX_WIDTH-1:0] older_r;
  logic [INDEX_WIDTH-1:0] newer_r;

  // result register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [INDEX_WIDTH-1:0] corner_one_r;
  logic [INDEX_WIDTH-1:0] corner_two_r;
  logic [INDEX_WIDTH-1:0] corner_three_r;

  logic                   emit;
  logic [INDEX_WIDTH-1:0] tri_one;
  logic [INDEX_WIDTH-1:0] tri_two;
  logic [INDEX_WIDTH-1:0] tri_three;
  logic                   in_take;
  logic                   advance;
  logic                   out_free;

  tpa_assemble #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_assemble (
    .cur_index    (s1_index_r),
    .part_kind    (s1_kind_r),
    .part_start   (s1_start_r),
    .ctrl         (ctrl_r),
    .anchor_index (anchor_r),
    .newer_index  (newer_r),
    .older_index  (older_r),
    .ctrl_nxt     (ctrl_nxt),
    .anchor_nxt   (anchor_nxt),
    .emit         (emit),
    .corner_one   (tri_one),
    .corner_two   (tri_two),
    .corner_three (tri_three)
  );

  // the held item moves on when it closes nothing or the result slot frees
  assign out_free = ~out_valid_r | out_chan.ready;
  assign advance  = s1_valid_r & (~emit | out_free);
  assign in_take  = in_chan.valid & in_chan.ready;

  assign in_chan.ready = ~s1_valid_r | advance;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and part state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= CTRL_RESET;
      anchor_r    <= '0;
      older_r     <= '0;
      newer_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        ctrl_r   <= ctrl_nxt;
        anchor_r <= anchor_nxt;
        older_r  <= newer_r;
        newer_r  <= s1_index_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_index_r <= in_chan.vertex_index;
      s1_kind_r  <= in_chan.part_kind;
      s1_start_r <= in_chan.part_start;
    end
    if (advance && emit) begin
      corner_one_r   <= tri_one;
      corner_two_r   <= tri_two;
      corner_three_r <= tri_three;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.corner_one   = corner_one_r;
  assign out_chan.corner_two   = corner_two_r;
  assign out_chan.corner_three = corner_three_r;

endmodule
